@@ hw/rtl/mrc_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the request checker.
// No dependencies; imported by every module of the block.
package mrc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FUNC_READ_HOLDING   = 8'd3;
	localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'd16;
	localparam logic [7:0] FUNC_EXC_FLAG       = 8'h80;
	localparam logic [7:0] BROADCAST_ID        = 8'h00;

	localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
	localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;

	localparam logic [8:0] BYTE_IDX_MAX   = 9'd511;
	localparam logic [8:0] MIN_LAST_INDEX = 9'd7;

	localparam logic [1:0] REG_STATION_ID     = 2'd0;
	localparam logic [1:0] REG_ADDRESS_OFFSET = 2'd1;
	localparam logic [1:0] REG_REGISTER_COUNT = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] EXC_LAST_BEAT = 3'd4;

	typedef enum logic {
		BK_IDLE,
		BK_EXC
	} back_state_t;

	// One checked frame handed from front to back
	typedef struct packed {
		logic        is_exc;
		logic [7:0]  exc_code;
		logic [7:0]  station;
		logic [7:0]  func_code;
		logic [15:0] start_addr;
		logic [15:0] quantity;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} rec_push_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/mrc_front.sv @@
// Front end: per-byte CRC, field capture and end-of-frame classification.
// Depends on mrc_pkg; pushes checked frames into mrc_queue.
module mrc_front import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_accept,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	input  logic [7:0]  station_id,
	input  logic [15:0] address_offset,
	input  logic [15:0] register_count,
	output rec_push_t   push
);

	logic [8:0]  byte_idx_q;
	logic [15:0] crc_q;
	logic [7:0]  held0_q, held1_q;
	logic [7:0]  station_q, func_q;
	logic [15:0] addr_q, qty_q;

	logic [15:0] crc_nxt;
	logic [15:0] rx_crc;
	logic [16:0] start_w;
	logic [16:0] end_w;
	logic        addr_bad, func_bad, keep;

	always_comb begin
		crc_nxt  = (byte_idx_q >= 9'd2) ? crc_byte(crc_q, held0_q) : crc_q;
		rx_crc   = {rx_byte, held1_q};
		start_w  = {1'b0, addr_q} - {1'b0, address_offset};
		end_w    = {1'b0, start_w[15:0]} + {1'b0, qty_q};
		addr_bad = (addr_q < address_offset) || (end_w > {1'b0, register_count});
		func_bad = (func_q != FUNC_READ_HOLDING) && (func_q != FUNC_WRITE_MULTIPLE);
		keep     = (byte_idx_q >= MIN_LAST_INDEX)
			&& ((station_q == station_id) || (station_q == BROADCAST_ID))
			&& (rx_crc == crc_nxt)
			// broadcasts never answer with an exception
			&& !((addr_bad || func_bad) && (station_q == BROADCAST_ID));

		push.valid          = in_accept && end_of_frame && keep;
		push.rec.is_exc     = addr_bad || func_bad;
		push.rec.exc_code   = addr_bad ? EXC_ILLEGAL_ADDRESS : EXC_ILLEGAL_FUNCTION;
		push.rec.station    = station_q;
		push.rec.func_code  = func_q;
		push.rec.start_addr = start_w[15:0];
		push.rec.quantity   = qty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			crc_q      <= CRC_INIT;
			held0_q    <= '0;
			held1_q    <= '0;
			station_q  <= '0;
			func_q     <= '0;
			addr_q     <= '0;
			qty_q      <= '0;
		end else if (in_accept) begin
			if (end_of_frame) begin
				byte_idx_q <= '0;
				crc_q      <= CRC_INIT;
				held0_q    <= '0;
				held1_q    <= '0;
				station_q  <= '0;
				func_q     <= '0;
				addr_q     <= '0;
				qty_q      <= '0;
			end else begin
				crc_q   <= crc_nxt;
				held0_q <= held1_q;
				held1_q <= rx_byte;
				if (byte_idx_q < BYTE_IDX_MAX)
					byte_idx_q <= byte_idx_q + 9'd1;
				case (byte_idx_q)
					9'd0: station_q <= rx_byte;
					9'd1: func_q <= rx_byte;
					9'd2: addr_q[15:8] <= rx_byte;
					9'd3: addr_q[7:0] <= rx_byte;
					9'd4: qty_q[15:8] <= rx_byte;
					9'd5: qty_q[7:0] <= rx_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/mrc_queue.sv @@
// Short queue of checked frames between front and back.
// Depends on mrc_pkg for the record type and depth.
module mrc_queue import mrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rec_push_t  push,
	input  logic       pop,
	output logic       full,
	output logic       rd_valid,
	output frame_rec_t rd_rec
);

	frame_rec_t              mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]       count_q;
	logic                    do_push, do_pop;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem[rd_ptr_q];
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/mrc_back.sv @@
// Back end: turns queued frames into result words, builds exception replies.
// Depends on mrc_pkg; holds the exception counter and the output register.
module mrc_back import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  frame_rec_t  q_rec,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic        out_last,
	output logic [63:0] out_data
);

	back_state_t state_q, state_nxt;
	frame_rec_t  rec_q;
	logic [2:0]  beat_q;
	logic [15:0] crc_q, exc_cnt_q;

	logic        ov_q, kind_q, last_q;
	logic [7:0]  byte_q, func_q;
	logic [15:0] start_q, qty_q, err_q;

	logic        adv, load, cnt_inc, crc_upd;
	logic        kind_n, last_n;
	logic [7:0]  byte_n, func_n;
	logic [15:0] start_n, qty_n, err_n, crc_n;

	// output register frees up when empty or being taken
	assign adv = !ov_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: if (adv && q_valid && q_rec.is_exc) state_nxt = BK_EXC;
			BK_EXC:  if (adv && beat_q == EXC_LAST_BEAT) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		load    = 1'b0;
		cnt_inc = 1'b0;
		crc_upd = 1'b0;
		kind_n  = 1'b1;
		last_n  = 1'b0;
		byte_n  = '0;
		func_n  = '0;
		start_n = '0;
		qty_n   = '0;
		err_n   = exc_cnt_q;
		crc_n   = crc_q;
		case (state_q)
			BK_IDLE: begin
				if (adv && q_valid) begin
					pop  = 1'b1;
					load = 1'b1;
					if (q_rec.is_exc) begin
						byte_n  = q_rec.station;
						err_n   = exc_cnt_q + 16'd1;
						cnt_inc = 1'b1;
						crc_upd = 1'b1;
						crc_n   = crc_byte(CRC_INIT, q_rec.station);
					end else begin
						kind_n  = 1'b0;
						last_n  = 1'b1;
						func_n  = q_rec.func_code;
						start_n = q_rec.start_addr;
						qty_n   = q_rec.quantity;
					end
				end
			end
			BK_EXC: begin
				load   = adv;
				last_n = (beat_q == EXC_LAST_BEAT);
				case (beat_q)
					3'd1: begin
						byte_n  = rec_q.func_code | FUNC_EXC_FLAG;
						crc_upd = adv;
						crc_n   = crc_byte(crc_q, byte_n);
					end
					3'd2: begin
						byte_n  = rec_q.exc_code;
						crc_upd = adv;
						crc_n   = crc_byte(crc_q, byte_n);
					end
					3'd3:    byte_n = crc_q[7:0];
					3'd4:    byte_n = crc_q[15:8];
					default: byte_n = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			beat_q    <= '0;
			exc_cnt_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop)
				beat_q <= 3'd1;
			else if (state_q == BK_EXC && load)
				beat_q <= beat_q + 3'd1;
			if (cnt_inc)
				exc_cnt_q <= exc_cnt_q + 16'd1;
			if (load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= q_rec;
		if (crc_upd)
			crc_q <= crc_n;
		if (load) begin
			kind_q  <= kind_n;
			last_q  <= last_n;
			byte_q  <= byte_n;
			func_q  <= func_n;
			start_q <= start_n;
			qty_q   <= qty_n;
			err_q   <= err_n;
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {err_q, qty_q, start_q, func_q, byte_q};

endmodule

@@ hw/rtl/modbus_rtu_request_checker_core.sv @@
// Top level of the Modbus RTU request checker: config registers, front, queue, back.
// Depends on mrc_pkg, mrc_front, mrc_queue and mrc_back.
//
// Received frame bytes enter on s_axis, one word per cycle, tlast on the final byte.
// The CRC-16 is stepped one byte per cycle in the front end, so bytes are taken every
// cycle unless the queue is full, the only stall on s_axis; at frame end a checked
// frame goes into a four-entry queue. Short, foreign and corrupted frames, and
// broadcasts that would fault, leave nothing. A valid request comes out as one word
// (tuser 0); an exception comes out as five reply bytes (tuser 1), paced by the back
// end's beat counter, with tlast on the last word of each run. Registers are written
// through cfg_we/cfg_index/cfg_wdata while idle, a user duty the block never checks.
module modbus_rtu_request_checker_core import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] tx_byte, [15:8] req_function, [31:16] req_start,
	// [47:32] req_quantity, [63:48] error_total
	output logic [63:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser,   // [0] result_kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [7:0]  station_id_q;
	logic [15:0] address_offset_q, register_count_q;

	rec_push_t   push;
	logic        q_full, q_valid, pop, in_accept;
	frame_rec_t  q_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q     <= 8'd1;
			address_offset_q <= '0;
			register_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATION_ID:     station_id_q <= cfg_wdata[7:0];
				REG_ADDRESS_OFFSET: address_offset_q <= cfg_wdata;
				REG_REGISTER_COUNT: register_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && !q_full;

	mrc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_accept      (in_accept),
		.rx_byte        (s_axis_tdata),
		.end_of_frame   (s_axis_tlast),
		.station_id     (station_id_q),
		.address_offset (address_offset_q),
		.register_count (register_count_q),
		.push           (push)
	);

	mrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_rec   (q_rec)
	);

	mrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rec     (q_rec),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser[0]),
		.out_last  (m_axis_tlast),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ sim/modbus_rtu_request_checker_core_tb.sv @@
// Testbench for modbus_rtu_request_checker_core: drives RTU frames as bytes and
// checks every reply word against a frame predictor held in the bench.
// Depends on mrc_pkg and the RTL of the request checker.
`timescale 1ns / 1ps

module modbus_rtu_request_checker_core_tb;
	import mrc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;

	typedef enum logic [2:0] {
		WANT_MODEL,
		WANT_NOTHING,
		WANT_REQUEST,
		WANT_EXC_ADDRESS,
		WANT_EXC_FUNCTION
	} want_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic        last;
		logic [7:0]  func;
		logic [15:0] start;
		logic [15:0] qty;
		logic [15:0] errs;
	} reply_word_t;

	typedef struct packed {
		logic [7:0]  cfg_st;
		logic [15:0] cfg_off;
		logic [15:0] cfg_cnt;
		logic [7:0]  station;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] qty;
		logic [9:0]  len;
		logic        crc_ok;
		want_t       want;
	} probe_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [7:0] tx_byte, [15:8] req_function, [31:16] req_start,
	// [47:32] req_quantity, [63:48] error_total
	logic [63:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;   // [0] result_kind
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// register copies
	logic [7:0]  cfg_station = 8'd1;
	logic [15:0] cfg_offset = '0;
	logic [15:0] cfg_count = '0;

	// frame state of the predictor
	logic [8:0]  fr_index = '0;
	logic [15:0] fr_crc = CRC_INIT;
	logic [7:0]  fr_hold [2] = '{8'h00, 8'h00};
	logic [7:0]  fr_station = '0;
	logic [7:0]  fr_func = '0;
	logic [15:0] fr_addr = '0;
	logic [15:0] fr_qty = '0;
	logic [15:0] exc_total = '0;
	want_t       frame_outcome = WANT_NOTHING;

	reply_word_t pending_replies [$];
	logic [7:0]  frame_buf [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_req = 1'b0;

	probe_t probes [18] = '{
		// reset values of the registers
		'{8'd1, 16'd0, 16'd0, 8'd1, FUNC_READ_HOLDING, 16'd0, 16'd0, 10'd8, 1'b1, WANT_REQUEST},
		'{8'd1, 16'd0, 16'd0, 8'd1, FUNC_READ_HOLDING, 16'd0, 16'd1, 10'd8, 1'b1,
			WANT_EXC_ADDRESS},
		'{8'd1, 16'd0, 16'd0, 8'd1, 8'd5, 16'd0, 16'd0, 10'd8, 1'b1, WANT_EXC_FUNCTION},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd100, 16'd200, 10'd8, 1'b1,
			WANT_REQUEST},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_WRITE_MULTIPLE, 16'd300, 16'd0, 10'd8, 1'b1,
			WANT_REQUEST},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_WRITE_MULTIPLE, 16'd300, 16'd1, 10'd8, 1'b1,
			WANT_EXC_ADDRESS},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd99, 16'd1, 10'd8, 1'b1,
			WANT_EXC_ADDRESS},
		'{8'd17, 16'd100, 16'd200, 8'd17, 8'hFF, 16'd100, 16'd1, 10'd8, 1'b1, WANT_EXC_FUNCTION},
		// broadcast that would fault stays silent
		'{8'd17, 16'd100, 16'd200, BROADCAST_ID, 8'd4, 16'd100, 16'd1, 10'd8, 1'b1,
			WANT_NOTHING},
		'{8'd17, 16'd100, 16'd200, BROADCAST_ID, FUNC_WRITE_MULTIPLE, 16'd150, 16'd10, 10'd8,
			1'b1, WANT_MODEL},
		'{8'd17, 16'd100, 16'd200, 8'd18, FUNC_READ_HOLDING, 16'd100, 16'd1, 10'd8, 1'b1,
			WANT_NOTHING},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd100, 16'd1, 10'd8, 1'b0,
			WANT_NOTHING},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd100, 16'd1, 10'd7, 1'b1,
			WANT_NOTHING},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd100, 16'd1, 10'd1, 1'b1,
			WANT_NOTHING},
		'{8'd17, 16'd100, 16'd200, 8'd17, FUNC_READ_HOLDING, 16'd120, 16'd5, 10'd12, 1'b1,
			WANT_MODEL},
		'{8'd247, 16'hFFFF, 16'hFFFF, 8'd247, FUNC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 10'd8, 1'b1,
			WANT_REQUEST},
		'{8'd247, 16'hFFFF, 16'hFFFF, 8'd247, FUNC_WRITE_MULTIPLE, 16'hFFFE, 16'd0, 10'd8, 1'b1,
			WANT_EXC_ADDRESS},
		'{8'd247, 16'hFFFF, 16'hFFFF, 8'd247, 8'd0, 16'hFFFF, 16'd0, 10'd8, 1'b1,
			WANT_EXC_FUNCTION}
	};

	modbus_rtu_request_checker_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	task automatic queue_exception(input logic [7:0] code);
		logic [7:0]  reply [5];
		logic [15:0] c;
		reply_word_t w;
		frame_outcome = WANT_NOTHING;
		if (fr_station == BROADCAST_ID)
			return;
		exc_total = exc_total + 16'd1;
		reply[0] = fr_station;
		reply[1] = fr_func | FUNC_EXC_FLAG;
		reply[2] = code;
		c = CRC_INIT;
		for (int k = 0; k < 3; k++)
			c = crc16_step(c, reply[k]);
		reply[3] = c[7:0];
		reply[4] = c[15:8];
		for (int k = 0; k < 5; k++) begin
			w = '0;
			w.kind = 1'b1;
			w.tx = reply[k];
			w.last = (k == 4);
			w.errs = exc_total;
			pending_replies.push_back(w);
		end
		frame_outcome = (code == EXC_ILLEGAL_ADDRESS) ? WANT_EXC_ADDRESS : WANT_EXC_FUNCTION;
	endtask

	task automatic close_frame();
		logic [16:0] rel;
		logic [17:0] span;
		reply_word_t w;
		frame_outcome = WANT_NOTHING;
		if (fr_index < MIN_LAST_INDEX)
			return;
		if (fr_station != cfg_station && fr_station != BROADCAST_ID)
			return;
		if ({fr_hold[1], fr_hold[0]} != fr_crc)
			return;
		if (fr_addr < cfg_offset) begin
			queue_exception(EXC_ILLEGAL_ADDRESS);
			return;
		end
		rel = {1'b0, fr_addr} - {1'b0, cfg_offset};
		span = {1'b0, rel} + {2'b00, fr_qty};
		if (span > {2'b00, cfg_count}) begin
			queue_exception(EXC_ILLEGAL_ADDRESS);
			return;
		end
		if (fr_func != FUNC_READ_HOLDING && fr_func != FUNC_WRITE_MULTIPLE) begin
			queue_exception(EXC_ILLEGAL_FUNCTION);
			return;
		end
		w = '0;
		w.last = 1'b1;
		w.func = fr_func;
		w.start = rel[15:0];
		w.qty = fr_qty;
		w.errs = exc_total;
		pending_replies.push_back(w);
		frame_outcome = WANT_REQUEST;
	endtask

	task automatic absorb_rx_byte(input logic [7:0] b, input logic eof);
		// the two newest bytes are held back, they may be the CRC
		if (fr_index >= 9'd2)
			fr_crc = crc16_step(fr_crc, fr_hold[0]);
		fr_hold[0] = fr_hold[1];
		fr_hold[1] = b;
		case (fr_index)
			9'd0: fr_station = b;
			9'd1: fr_func = b;
			9'd2: fr_addr[15:8] = b;
			9'd3: fr_addr[7:0] = b;
			9'd4: fr_qty[15:8] = b;
			9'd5: fr_qty[7:0] = b;
			default: ;
		endcase
		if (!eof) begin
			if (fr_index < BYTE_IDX_MAX)
				fr_index = fr_index + 9'd1;
			return;
		end
		close_frame();
		fr_index = '0;
		fr_crc = CRC_INIT;
		fr_hold[0] = '0;
		fr_hold[1] = '0;
		fr_station = '0;
		fr_func = '0;
		fr_addr = '0;
		fr_qty = '0;
	endtask

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_reply_word();
		reply_word_t w;
		if (pending_replies.size() == 0) begin
			$error("reply word with nothing pending: tuser %0d tdata %h",
				m_axis_tuser[0], m_axis_tdata);
			fail_count++;
			return;
		end
		w = pending_replies.pop_front();
		compare_field("result_kind", w.kind, m_axis_tuser[0]);
		compare_field("tx_byte", w.tx, m_axis_tdata[7:0]);
		compare_field("last_of_run", w.last, m_axis_tlast);
		compare_field("req_function", w.func, m_axis_tdata[15:8]);
		compare_field("req_start", w.start, m_axis_tdata[31:16]);
		compare_field("req_quantity", w.qty, m_axis_tdata[47:32]);
		compare_field("error_total", w.errs, m_axis_tdata[63:48]);
	endtask

	// prediction first, so a word caused at this edge is already queued
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			absorb_rx_byte(s_axis_tdata, s_axis_tlast);
		if (m_axis_tvalid && m_axis_tready)
			check_reply_word();
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// reply side; a long hold-off is counted here when asked for
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// starts and ends at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eof;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic build_frame(input logic [7:0] station, input logic [7:0] func,
			input logic [15:0] addr, input logic [15:0] qty, input int len, input logic crc_ok);
		logic [7:0]  head [6];
		logic [7:0]  b;
		logic [15:0] c;
		int          nbody;
		head = '{station, func, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
		nbody = (len >= 2) ? len - 2 : len;
		frame_buf = {};
		c = CRC_INIT;
		for (int i = 0; i < nbody; i++) begin
			b = (i < 6) ? head[i] : 8'($urandom);
			frame_buf.push_back(b);
			c = crc16_step(c, b);
		end
		if (len >= 2) begin
			if (!crc_ok)
				c = c ^ (16'h0001 << $urandom_range(15));
			frame_buf.push_back(c[7:0]);
			frame_buf.push_back(c[15:8]);
		end
	endtask

	// mostly well-formed requests around the configured window, some noise
	task automatic random_frame();
		logic [7:0]  station;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] qty;
		int          pick;
		int          len;
		pick = $urandom_range(99);
		station = cfg_station;
		if (pick < 8)
			station = BROADCAST_ID;
		else if (pick < 14)
			station = 8'($urandom);
		func = $urandom_range(1) ? FUNC_READ_HOLDING : FUNC_WRITE_MULTIPLE;
		if ($urandom_range(9) == 0)
			func = 8'($urandom);
		if ($urandom_range(2) == 0)
			qty = 16'($urandom_range(8));
		else
			qty = 16'($urandom_range(cfg_count));
		if (qty <= cfg_count)
			addr = cfg_offset + 16'($urandom_range(cfg_count - qty));
		else
			addr = cfg_offset + 16'($urandom_range(3));
		if ($urandom_range(9) == 0) begin
			addr = 16'($urandom);
			qty = 16'($urandom);
		end
		pick = $urandom_range(99);
		len = 8;
		if (pick < 8)
			len = $urandom_range(7, 1);
		else if (pick < 23)
			len = $urandom_range(16, 9);
		build_frame(station, func, addr, qty, len, $urandom_range(9) != 0);
	endtask

	task automatic send_random(input int min_bytes);
		int sent;
		sent = 0;
		while (sent < min_bytes) begin
			random_frame();
			send_frame();
			sent += frame_buf.size();
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [7:0] st, input logic [15:0] off,
			input logic [15:0] cnt);
		wait_drained();
		write_reg(REG_STATION_ID, {8'h00, st});
		write_reg(REG_ADDRESS_OFFSET, off);
		write_reg(REG_REGISTER_COUNT, cnt);
		cfg_we <= 1'b0;
		cfg_station = st;
		cfg_offset = off;
		cfg_count = cnt;
	endtask

	task automatic run_phase(input logic [7:0] st, input logic [15:0] off,
			input logic [15:0] cnt, input int idle_pct, input int stall_pct, input int nbytes);
		apply_config(st, off, cnt);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		send_random(nbytes);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_STATION_ID;
		cfg_wdata = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probes[i]) begin
			if (probes[i].cfg_st != cfg_station || probes[i].cfg_off != cfg_offset ||
					probes[i].cfg_cnt != cfg_count)
				apply_config(probes[i].cfg_st, probes[i].cfg_off, probes[i].cfg_cnt);
			build_frame(probes[i].station, probes[i].func, probes[i].addr, probes[i].qty,
				probes[i].len, probes[i].crc_ok);
			send_frame();
			if (probes[i].want != WANT_MODEL && probes[i].want != frame_outcome) begin
				$error("frame outcome: expected %s, got %s", probes[i].want.name(),
					frame_outcome.name());
				fail_count++;
			end
		end

		run_phase(8'd247, 16'hFFFF, 16'hFFFF, 0, 0, 8);
		run_phase(8'd1, 16'd0, 16'hFFFF, 67, 0, 8);
		run_phase(8'($urandom_range(247, 1)), 16'($urandom_range(300)),
			16'($urandom_range(64)), 0, 67, 8);
		run_phase(8'($urandom_range(247, 1)), 16'd0, 16'd0, 28, 28, 8);
		run_phase(8'd9, 16'd40, 16'd100, 0, 0, 0);
		// reply side blocked while valid frames keep coming: the queue fills, input stalls
		hold_req = 1'b1;
		repeat (6) begin
			build_frame(8'd9, FUNC_READ_HOLDING, 16'd40, 16'd1, 8, 1'b1);
			send_frame();
		end
		// the next phase first waits for every expected word
		run_phase(8'd200, 16'd1000, 16'd500, 28, 28, 16);

		s_axis_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && pending_replies.size() != 0; w++)
			@(negedge clk);
		if (pending_replies.size() != 0) begin
			$error("%0d reply words never arrived", pending_replies.size());
			fail_count++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
